// ===== rtl/core/atatf_pkg.sv =====
// ----------------------------------------------------------------------------
// atatf_pkg
// Shared types and constants for the ATA task-file command issue block.
// ----------------------------------------------------------------------------
package atatf_pkg;

   localparam int MAX_SLOTS     = 4;
   localparam int NUM_SLOTS_DEF = 4;

   localparam int SLOT_W      = 3;
   localparam int LBA_W       = 32;
   localparam int COUNT_W     = 8;
   localparam int SECTORS_W   = 32;
   localparam int SLOT_FLAG_W = 5;
   localparam int FLAGS_W     = MAX_SLOTS * SLOT_FLAG_W;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_IDX_LSB = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_FLAGS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_SECTORS = 3'd1;

   // per-slot flag bits
   localparam int FLAG_PRESENT = 0;
   localparam int FLAG_ATAPI   = 1;
   localparam int FLAG_LBA     = 2;
   localparam int FLAG_CHANNEL = 3;
   localparam int FLAG_UNIT    = 4;

   // CHS split: q = lba / 63 by reciprocal, corrected by one subtract
   localparam int                  LBA28_W     = 28;
   localparam int                  RECIP_W     = 29;
   localparam logic [RECIP_W-1:0]  RECIP_63    = 29'd272696336;
   localparam int                  RECIP_SHIFT = 34;
   localparam int                  PROD_W      = LBA28_W + RECIP_W;
   localparam int                  QUOT_W      = 23;
   localparam int                  REM_W       = 7;
   localparam logic [REM_W-1:0]    CHS_SECTORS = 7'd63;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_DEVICE = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;
   localparam logic [1:0] STATUS_ATAPI     = 2'd3;

   localparam logic [3:0] REG_NONE     = 4'd0;
   localparam logic [3:0] REG_COUNT    = 4'd2;
   localparam logic [3:0] REG_LBA0     = 4'd3;
   localparam logic [3:0] REG_LBA1     = 4'd4;
   localparam logic [3:0] REG_LBA2     = 4'd5;
   localparam logic [3:0] REG_DEVICE   = 4'd6;
   localparam logic [3:0] REG_COMMAND  = 4'd7;
   localparam logic [3:0] REG_COUNT_HI = 4'd8;
   localparam logic [3:0] REG_LBA3     = 4'd9;
   localparam logic [3:0] REG_LBA4     = 4'd10;
   localparam logic [3:0] REG_LBA5     = 4'd11;

   localparam logic [7:0] DEV_CHS       = 8'hA0;
   localparam logic [7:0] DEV_LBA       = 8'hE0;
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_READ_EXT  = 8'h24;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

   typedef logic [MAX_SLOTS-1:0][SLOT_FLAG_W-1:0] slot_flags_type;

   typedef enum logic [1:0] {
      ADDR_CHS   = 2'd0,
      ADDR_LBA28 = 2'd1,
      ADDR_LBA48 = 2'd2
   } addr_mode_type;

   typedef struct packed {
      logic               mode;
      logic [SLOT_W-1:0]  drive_slot;
      logic [LBA_W-1:0]   block_address;
      logic [COUNT_W-1:0] sector_count;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic       channel;
      logic [3:0] reg_index;
      logic [7:0] reg_value;
      logic       write_valid;
      logic       last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               channel;
      logic               unit;
      logic               dir;
      addr_mode_type      addr_mode;
      logic [LBA_W-1:0]   lba;
      logic [COUNT_W-1:0] count;
      logic [QUOT_W-1:0]  quot;
   } job_type;

endpackage

// ===== rtl/core/atatf_csr.sv =====
// ----------------------------------------------------------------------------
// atatf_csr
// Register file: slot flags and per-slot capacities on an APB-style port.
// ----------------------------------------------------------------------------
module atatf_csr
   import atatf_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [CSR_ADDR_W-1:0]                paddr,
   input  logic [CSR_DATA_W-1:0]                pwdata,
   output logic [CSR_DATA_W-1:0]                prdata,
   output logic                                 pready,
   output slot_flags_type                       slot_flags,
   output logic [NUM_SLOTS-1:0][SECTORS_W-1:0]  slot_sectors
);

   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   slot_flags_type                      flags_ff;
   logic [NUM_SLOTS-1:0][SECTORS_W-1:0] sectors_ff;
   logic [CSR_IDX_W-1:0]                idx;
   logic [CSR_IDX_W-1:0]                sec_idx;
   logic                                wr_en;

   assign idx     = paddr[CSR_IDX_LSB +: CSR_IDX_W];
   assign sec_idx = idx - CSR_SLOT0_SECTORS;
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         sectors_ff <= '0;
      end else if (wr_en) begin
         if (idx == CSR_SLOT_FLAGS) begin
            flags_ff <= pwdata[FLAGS_W-1:0];
         end
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (idx == CSR_SLOT0_SECTORS + CSR_IDX_W'(s)) begin
               sectors_ff[s] <= pwdata[SECTORS_W-1:0];
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      priority if (idx == CSR_SLOT_FLAGS) begin
         prdata = CSR_DATA_W'(flags_ff);
      end else if (idx >= CSR_SLOT0_SECTORS &&
                   idx < CSR_SLOT0_SECTORS + CSR_IDX_W'(NUM_SLOTS)) begin
         prdata = sectors_ff[sec_idx[SLOT_IDX_W-1:0]];
      end
   end

   assign slot_flags   = flags_ff;
   assign slot_sectors = sectors_ff;

endmodule

// ===== rtl/core/atatf_decode.sv =====
// ----------------------------------------------------------------------------
// atatf_decode
// Request register and decode: slot checks, range check, addressing mode
// and the reciprocal product for the CHS split.
// ----------------------------------------------------------------------------
module atatf_decode
   import atatf_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  req_item_type                         req_item,
   input  slot_flags_type                       slot_flags,
   input  logic [NUM_SLOTS-1:0][SECTORS_W-1:0]  slot_sectors,
   input  logic                                 job_free,
   output logic                                 load,
   output job_type                              job
);

   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   req_item_type            in_ff;
   logic                    in_valid_ff;
   logic                    in_valid_in;
   logic                    accept;
   logic                    slot_ok;
   logic [SLOT_FLAG_W-1:0]  fl;
   logic [SECTORS_W-1:0]    cap;
   logic [LBA_W:0]          end_blk;
   logic                    over;
   logic [PROD_W-1:0]       prod;

   assign busy   = in_valid_ff & ~job_free;
   assign accept = start & ~busy;
   assign load   = in_valid_ff & job_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_item;
      end
   end

   assign slot_ok = in_ff.drive_slot < SLOT_W'(NUM_SLOTS);
   assign fl      = slot_flags[in_ff.drive_slot[1:0]];
   assign cap     = slot_sectors[in_ff.drive_slot[SLOT_IDX_W-1:0]];
   assign end_blk = {1'b0, in_ff.block_address} + (LBA_W+1)'(in_ff.sector_count);
   assign over    = end_blk > {1'b0, cap};
   assign prod    = PROD_W'(in_ff.block_address[LBA28_W-1:0]) * PROD_W'(RECIP_63);

   always_comb begin
      job.channel   = fl[FLAG_CHANNEL];
      job.unit      = fl[FLAG_UNIT];
      job.dir       = in_ff.mode;
      job.lba       = in_ff.block_address;
      job.count     = in_ff.sector_count;
      job.quot      = prod[RECIP_SHIFT +: QUOT_W];
      priority if (!slot_ok || !fl[FLAG_PRESENT]) begin
         job.status  = STATUS_NO_DEVICE;
         job.channel = 1'b0;
      end else if (fl[FLAG_ATAPI]) begin
         job.status  = STATUS_ATAPI;
      end else if (over) begin
         job.status  = STATUS_RANGE;
      end else begin
         job.status  = STATUS_OK;
      end
      priority if (in_ff.block_address[LBA_W-1:LBA28_W] != '0) begin
         job.addr_mode = ADDR_LBA48;
      end else if (fl[FLAG_LBA]) begin
         job.addr_mode = ADDR_LBA28;
      end else begin
         job.addr_mode = ADDR_CHS;
      end
   end

endmodule

// ===== rtl/core/atatf_emit.sv =====
// ----------------------------------------------------------------------------
// atatf_emit
// Write sequencer: steps through the task-file writes of one decoded
// request, one registered result per cycle.
// ----------------------------------------------------------------------------
module atatf_emit
   import atatf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  job_type       job_in,
   output logic          job_free,
   output logic          rsp_valid,
   output rsp_item_type  rsp_item
);

   localparam logic [3:0] STEP_DEV     = 4'd0;
   localparam logic [3:0] STEP_CNT_HI  = 4'd1;
   localparam logic [3:0] STEP_LBA3    = 4'd2;
   localparam logic [3:0] STEP_LBA4    = 4'd3;
   localparam logic [3:0] STEP_LBA5    = 4'd4;
   localparam logic [3:0] STEP_COUNT   = 4'd5;
   localparam logic [3:0] STEP_LBA0    = 4'd6;
   localparam logic [3:0] STEP_LBA1    = 4'd7;
   localparam logic [3:0] STEP_LBA2    = 4'd8;
   localparam logic [3:0] STEP_CMD     = 4'd9;

   job_type               job_ff;
   logic                  job_valid_ff;
   logic                  job_valid_in;
   logic [3:0]            step_ff;
   logic [3:0]            step_in;
   logic                  job_last;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_ff;
   rsp_item_type          rsp_in;

   logic [LBA28_W:0]      q63;
   logic [LBA28_W:0]      rem_full;
   logic [REM_W-1:0]      rem0;
   logic [REM_W-1:0]      rem;
   logic [QUOT_W-1:0]     quot;
   logic [7:0]            b0;
   logic [7:0]            b1;
   logic [7:0]            b2;
   logic [3:0]            head;
   logic [7:0]            dev_val;
   logic [7:0]            cmd_val;
   logic                  is_48;

   assign job_last = job_valid_ff & ((job_ff.status != STATUS_OK) | (step_ff == STEP_CMD));
   assign job_free = ~job_valid_ff | job_last;
   assign is_48    = job_ff.addr_mode == ADDR_LBA48;

   always_comb begin
      job_valid_in = job_valid_ff;
      step_in      = step_ff;
      priority if (load) begin
         job_valid_in = 1'b1;
         step_in      = STEP_DEV;
      end else if (job_last) begin
         job_valid_in = 1'b0;
         step_in      = STEP_DEV;
      end else if (job_valid_ff) begin
         step_in = (step_ff == STEP_DEV && !is_48) ? STEP_COUNT : step_ff + 4'd1;
      end
   end

   // CHS: correct the reciprocal quotient, then split into cylinder/head/sector
   assign q63      = {job_ff.quot, 6'b0} - (LBA28_W+1)'(job_ff.quot);
   assign rem_full = (LBA28_W+1)'(job_ff.lba[LBA28_W-1:0]) - q63;
   assign rem0     = rem_full[REM_W-1:0];

   always_comb begin
      if (rem0 >= CHS_SECTORS) begin
         rem  = rem0 - CHS_SECTORS;
         quot = job_ff.quot + QUOT_W'(1);
      end else begin
         rem  = rem0;
         quot = job_ff.quot;
      end
   end

   always_comb begin
      unique case (job_ff.addr_mode)
         ADDR_CHS: begin
            b0      = 8'(rem) + 8'd1;
            b1      = quot[11:4];
            b2      = quot[19:12];
            head    = quot[3:0];
            dev_val = DEV_CHS;
         end
         ADDR_LBA28: begin
            b0      = job_ff.lba[7:0];
            b1      = job_ff.lba[15:8];
            b2      = job_ff.lba[23:16];
            head    = job_ff.lba[27:24];
            dev_val = DEV_LBA;
         end
         default: begin
            b0      = job_ff.lba[7:0];
            b1      = job_ff.lba[15:8];
            b2      = job_ff.lba[23:16];
            head    = 4'd0;
            dev_val = DEV_LBA;
         end
      endcase
      if (job_ff.dir) begin
         cmd_val = is_48 ? CMD_WRITE_EXT : CMD_WRITE;
      end else begin
         cmd_val = is_48 ? CMD_READ_EXT : CMD_READ;
      end
   end

   always_comb begin
      rsp_in.status      = job_ff.status;
      rsp_in.channel     = job_ff.channel;
      rsp_in.write_valid = 1'b1;
      rsp_in.last        = 1'b0;
      rsp_in.reg_index   = REG_NONE;
      rsp_in.reg_value   = 8'd0;
      if (job_ff.status != STATUS_OK) begin
         rsp_in.write_valid = 1'b0;
         rsp_in.last        = 1'b1;
      end else begin
         unique case (step_ff)
            STEP_DEV: begin
               rsp_in.reg_index = REG_DEVICE;
               rsp_in.reg_value = dev_val | {3'b0, job_ff.unit, head};
            end
            STEP_CNT_HI: rsp_in.reg_index = REG_COUNT_HI;
            STEP_LBA3: begin
               rsp_in.reg_index = REG_LBA3;
               rsp_in.reg_value = job_ff.lba[31:24];
            end
            STEP_LBA4:   rsp_in.reg_index = REG_LBA4;
            STEP_LBA5:   rsp_in.reg_index = REG_LBA5;
            STEP_COUNT: begin
               rsp_in.reg_index = REG_COUNT;
               rsp_in.reg_value = job_ff.count;
            end
            STEP_LBA0: begin
               rsp_in.reg_index = REG_LBA0;
               rsp_in.reg_value = b0;
            end
            STEP_LBA1: begin
               rsp_in.reg_index = REG_LBA1;
               rsp_in.reg_value = b1;
            end
            STEP_LBA2: begin
               rsp_in.reg_index = REG_LBA2;
               rsp_in.reg_value = b2;
            end
            STEP_CMD: begin
               rsp_in.reg_index = REG_COMMAND;
               rsp_in.reg_value = cmd_val;
               rsp_in.last      = 1'b1;
            end
            default: rsp_in.write_valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         step_ff      <= STEP_DEV;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= job_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         job_ff <= job_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> job_free)
      else $error("job loaded while sequencer busy");

   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |=> rsp_valid_ff)
      else $error("gap inside a request's results");

   a_ok_ends_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last && rsp_ff.status == STATUS_OK
      |-> rsp_ff.reg_index == REG_COMMAND)
      else $error("successful request not closed by command write");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> step_ff <= STEP_CMD)
      else $error("step counter out of range");
`endif

endmodule

// ===== rtl/core/ata_taskfile_command_issue_top.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_command_issue_top
// Turns a sector read/write request into the ordered ATA task-file writes
// (LBA48, LBA28 or CHS addressing), or one error result.
// A request passes the request register and the job register; its first result
// comes from the result register. One result per cycle while a request is
// sequencing: ten task-file writes (LBA48), six (LBA28/CHS) or one error result.
// Next request is taken while the previous one is still sequencing.
// Synchronous reset clears control state and CSR registers, not data registers.
// ----------------------------------------------------------------------------
module ata_taskfile_command_issue_top
   import atatf_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   output rsp_item_type           rsp_item,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   slot_flags_type                      slot_flags;
   logic [NUM_SLOTS-1:0][SECTORS_W-1:0] slot_sectors;
   logic                                job_free;
   logic                                load;
   job_type                             job;

   atatf_csr #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .slot_flags   (slot_flags),
      .slot_sectors (slot_sectors)
   );

   atatf_decode #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_decode (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_item     (req_item),
      .slot_flags   (slot_flags),
      .slot_sectors (slot_sectors),
      .job_free     (job_free),
      .load         (load),
      .job          (job)
   );

   atatf_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .job_in    (job),
      .job_free  (job_free),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
